@@ design/smma_pkg.sv @@
package smma_pkg;

	localparam int MAX_DIM = 8;
	localparam int IDX_W = 3;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CFG_DIM_W = 4;
	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int A_W = 16;
	localparam int C_W = 32;
	localparam int PROD_W = 2 * A_W;
	localparam int SUM_W = C_W + 1 + $clog2(MAX_DIM + 1);
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [CFG_DIM_W-1:0] DIM_RESET = CFG_DIM_W'(MAX_DIM);

	typedef enum logic [1:0] {
		REQ_WR_A,
		REQ_WR_B,
		REQ_WR_C,
		REQ_COMPUTE
	} req_t;

	typedef enum logic [PADDR_W-3:0] {
		REG_DIM
	} reg_t;

	typedef struct packed {
		logic                    valid;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [SUM_W-1:0] sum;
	} tok_t;

	typedef struct packed {
		logic                  we_a;
		logic                  we_b;
		logic [IDX_W-1:0]      row;
		logic [IDX_W-1:0]      col;
		logic signed [A_W-1:0] data;
	} ewr_t;

endpackage

@@ design/square_matrix_multiply_accumulate.sv @@
// Square matrix multiply-accumulate, C = C + A*B, one element of C per compute transaction.
// The request channel (req_valid, req_stall) carries req_type, row, col and value. Write
// transactions load one element of A, B or C; A and B values are
// clipped to 16 bits. A compute transaction adds the dot product of row "row" of A and
// column "col" of B to C[row][col], stores the sum back and returns it on the result
// channel (res_valid, res_stall) together with its indices and a saturation flag.
// Indices at or beyond the dimension in use make a transaction a no-op.
// A compute result passes through these registers in order: the C memory is read at the
// accepting edge, each cell of the MAX_DIM-cell multiply-accumulate chain registers the
// partial sum, the clipped sum is written back to C and into a holding register, and from
// there it moves into the output register when that is free. Cells beyond the dimension
// in use pass the partial sum on unchanged, so the path does not depend on dim.
// req_stall is high from acceptance of a compute until its result reaches the output
// register, so computes run one at a time; writes and the next compute may be taken
// while a result waits under res_stall.
// Reset sets dim to 8 and marks every C element as zero through per-element valid bits, with
// no clearing pass; A and B are undefined until written. dim is register 0 of the APB port.
module square_matrix_multiply_accumulate import smma_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           req_type,
	input  logic [IDX_W-1:0]     row,
	input  logic [IDX_W-1:0]     col,
	input  logic signed [C_W-1:0] value,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [IDX_W-1:0]     row_res,
	output logic [IDX_W-1:0]     col_res,
	output logic signed [C_W-1:0] value_res,
	output logic                 saturated
);

	logic [CFG_DIM_W-1:0]    dim_q;
	logic [DIM_W-1:0]        dim_eff;
	logic                    busy_q;
	logic                    req_acc;
	logic                    in_range;
	logic                    start;
	logic                    start_s1;
	logic [IDX_W-1:0]        row_s1;
	logic [IDX_W-1:0]        col_s1;
	logic                    cvld_s1;
	logic [CELLS-1:0]        cvld_q;
	logic [ADDR_W-1:0]       req_addr;
	logic [ADDR_W-1:0]       end_addr;
	logic                    c_we;
	logic [ADDR_W-1:0]       c_waddr;
	logic [C_W-1:0]          c_wdata;
	logic [C_W-1:0]          c_rdata;
	ewr_t                    ewr;
	tok_t                    tok [MAX_DIM+1];
	logic signed [C_W-1:0]   end_val;
	logic                    end_sat;
	logic                    fin_v_q;
	logic [IDX_W-1:0]        fin_row_q;
	logic [IDX_W-1:0]        fin_col_q;
	logic signed [C_W-1:0]   fin_val_q;
	logic                    fin_sat_q;
	logic                    fin_move;

	function automatic logic signed [A_W-1:0] sat16(input logic signed [C_W-1:0] v);
		logic signed [A_W-1:0] r;
		if (v > C_W'(32767)) begin
			r = A_W'(32767);
		end else if (v < -C_W'(32768)) begin
			r = A_W'(-32768);
		end else begin
			r = v[A_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		return ADDR_W'(r * MAX_DIM + c);
	endfunction

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_DIM) ? PDATA_W'(dim_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
		end else if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_DIM) begin
			dim_q <= pwdata[CFG_DIM_W-1:0];
		end
	end

	always_comb begin
		if (dim_q == '0) begin
			dim_eff = DIM_W'(1);
		end else if (dim_q > CFG_DIM_W'(MAX_DIM)) begin
			dim_eff = DIM_W'(MAX_DIM);
		end else begin
			dim_eff = DIM_W'(dim_q);
		end
	end

	// Request decode.
	assign req_stall = busy_q;
	assign req_acc = req_valid && !req_stall;
	assign in_range = (DIM_W'(row) < dim_eff) && (DIM_W'(col) < dim_eff);
	assign start = req_acc && in_range && req_type == REQ_COMPUTE;
	assign req_addr = elem_addr(row, col);

	assign ewr.we_a = req_acc && in_range && req_type == REQ_WR_A;
	assign ewr.we_b = req_acc && in_range && req_type == REQ_WR_B;
	assign ewr.row = row;
	assign ewr.col = col;
	assign ewr.data = sat16(value);

	// C store: the chain end writes back while busy, so a C write from the request
	// side never collides with it.
	assign end_addr = elem_addr(tok[MAX_DIM].row, tok[MAX_DIM].col);
	assign c_we = tok[MAX_DIM].valid || (req_acc && in_range && req_type == REQ_WR_C);
	assign c_waddr = tok[MAX_DIM].valid ? end_addr : req_addr;
	assign c_wdata = tok[MAX_DIM].valid ? end_val : value;

	smma_ram #(
		.WIDTH(C_W),
		.DEPTH(CELLS)
	) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (req_addr),
		.rdata (c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q <= '0;
			start_s1 <= 1'b0;
		end else begin
			if (c_we) begin
				cvld_q[c_waddr] <= 1'b1;
			end
			start_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= row;
		col_s1 <= col;
		cvld_s1 <= cvld_q[req_addr];
	end

	// Multiply-accumulate chain.
	assign tok[0].valid = start_s1;
	assign tok[0].row = row_s1;
	assign tok[0].col = col_s1;
	assign tok[0].sum = cvld_s1 ? SUM_W'($signed(c_rdata)) : '0;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		smma_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(k)),
			.dim_eff  (dim_eff),
			.ewr      (ewr),
			.tok_in   (tok[k]),
			.tok_out  (tok[k+1])
		);
	end

	always_comb begin
		if (tok[MAX_DIM].sum > SUM_W'(32'sh7fffffff)) begin
			end_val = 32'sh7fffffff;
			end_sat = 1'b1;
		end else if (tok[MAX_DIM].sum < SUM_W'(-33'sh080000000)) begin
			end_val = 32'sh80000000;
			end_sat = 1'b1;
		end else begin
			end_val = tok[MAX_DIM].sum[C_W-1:0];
			end_sat = 1'b0;
		end
	end

	// Result holding register and output register.
	assign fin_move = fin_v_q && (!res_valid || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_v_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (fin_move) begin
				busy_q <= 1'b0;
			end
			if (tok[MAX_DIM].valid) begin
				fin_v_q <= 1'b1;
			end else if (fin_move) begin
				fin_v_q <= 1'b0;
			end
			if (fin_move) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[MAX_DIM].valid) begin
			fin_row_q <= tok[MAX_DIM].row;
			fin_col_q <= tok[MAX_DIM].col;
			fin_val_q <= end_val;
			fin_sat_q <= end_sat;
		end
		if (fin_move) begin
			row_res <= fin_row_q;
			col_res <= fin_col_q;
			value_res <= fin_val_q;
			saturated <= fin_sat_q;
		end
	end

endmodule

@@ design/smma_ram.sv @@
module smma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/smma_cell.sv @@
module smma_cell import smma_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [DIM_W-1:0] dim_eff,
	input  ewr_t             ewr,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	logic signed [A_W-1:0]    a_q [MAX_DIM];
	logic signed [A_W-1:0]    b_q [MAX_DIM];
	logic signed [PROD_W-1:0] prod;
	logic                     active;
	logic signed [SUM_W-1:0]  sum_next;

	always_ff @(posedge clk) begin
		if (ewr.we_a && ewr.col == cell_idx) begin
			a_q[ewr.row] <= ewr.data;
		end
		if (ewr.we_b && ewr.row == cell_idx) begin
			b_q[ewr.col] <= ewr.data;
		end
	end

	assign active = DIM_W'(cell_idx) < dim_eff;
	assign prod = a_q[tok_in.row] * b_q[tok_in.col];
	assign sum_next = active ? tok_in.sum + SUM_W'(prod) : tok_in.sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= '{valid: tok_in.valid, row: tok_in.row, col: tok_in.col, sum: sum_next};
		end
	end

endmodule

@@ design/smma_checker.sv @@
module smma_checker import smma_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input logic [1:0]           req_type,
	input logic [IDX_W-1:0]     row,
	input logic [IDX_W-1:0]     col,
	input logic                 res_valid,
	input logic                 res_stall,
	input logic signed [C_W-1:0] value_res,
	input logic                 saturated
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(value_res) && $stable(saturated))
		else $error("Stalled result transaction changed or vanished.");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type == REQ_COMPUTE && row == '0 && col == '0
		|=> req_stall)
		else $error("Request side not stalled while a compute is in progress.");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type != REQ_COMPUTE |=> !req_stall)
		else $error("Write transaction left the request side stalled.");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && saturated |-> value_res == 32'sh7fffffff || value_res == 32'sh80000000)
		else $error("Saturated result is not a range limit.");

endmodule

bind square_matrix_multiply_accumulate smma_checker u_smma_checker (.*);
